@@ sv/dfs_pkg.sv @@
package dfs_pkg;

	localparam int MAG_W   = 16;
	localparam int SCALE_W = 32;
	localparam int FIELD_W = 32;
	localparam int FRAC_W  = 28;
	localparam int CIDX_W  = 3;
	localparam int DIV_W   = 19;
	localparam int PROD_W  = 32;
	localparam int DOT_W   = 34;
	localparam int GRAD_W  = 36;
	localparam int T_W     = 38;
	localparam int TH_W    = T_W - FRAC_W;
	localparam int LO_W    = FRAC_W + 1 + SCALE_W;
	localparam int HI_W    = TH_W + SCALE_W;
	localparam int R_W     = HI_W + 2;
	localparam int SETTLE_CYC = 3;

	localparam logic [CIDX_W-1:0] CFG_SIZE_X = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_SIZE_Y = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_SIZE_Z = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_AXIS_X = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_AXIS_Y = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_AXIS_Z = 3'd5;
	localparam logic [CIDX_W-1:0] CFG_SCALE  = 3'd6;

	localparam logic [2:0] NBR_LAST = 3'd5;
	localparam logic [2:0] SC_LAST  = 3'd3;

	typedef enum logic [2:0] {
		ST_SETTLE,
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_TERM,
		ST_SCALE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       accept;
		logic       rd_en;
		logic [2:0] rd_idx;
		logic       term_en;
		logic       sc_en;
		logic [1:0] sc_comp;
		logic       load_out;
	} dfs_cmd_t;

	typedef struct packed {
		logic produce;
		logic size_wr;
	} dfs_stat_t;

endpackage

@@ sv/dfs_ctrl.sv @@
module dfs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             out_stall,
	input  dfs_pkg::dfs_stat_t stat,
	output logic             in_stall,
	output logic             out_valid,
	output dfs_pkg::dfs_cmd_t  cmd
);
	import dfs_pkg::*;

	state_t     state_q, state_d;
	logic [2:0] cnt_q, cnt_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SETTLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_SETTLE: begin
				if (cnt_q == 3'(SETTLE_CYC - 1)) begin
					state_d = ST_IDLE;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			ST_IDLE: begin
				in_stall = stat.size_wr;
				if (in_valid && !stat.size_wr) begin
					cmd.accept = 1'b1;
					if (stat.produce) begin
						state_d = ST_READ;
						cnt_d   = '0;
					end
				end
			end
			ST_READ: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_idx = cnt_q;
				if (cnt_q == NBR_LAST) begin
					state_d = ST_WAIT;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			ST_WAIT: begin
				// read data and product stages drain into the accumulators
				if (cnt_q == 3'd1) begin
					state_d = ST_TERM;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			ST_TERM: begin
				cmd.term_en = 1'b1;
				state_d     = ST_SCALE;
				cnt_d       = '0;
			end
			ST_SCALE: begin
				if (cnt_q != SC_LAST) begin
					cmd.sc_en   = 1'b1;
					cmd.sc_comp = cnt_q[1:0];
					cnt_d       = cnt_q + 3'd1;
				end else begin
					state_d = ST_OUT;
					cnt_d   = '0;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_SETTLE;
				cnt_d   = '0;
			end
		endcase
		if (stat.size_wr) begin
			state_d = ST_SETTLE;
			cnt_d   = '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ sv/dfs_datapath.sv @@
module dfs_datapath #(
	parameter int MAX_X = 64,
	parameter int MAX_Y = 64,
	parameter int MAX_Z = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dfs_pkg::dfs_cmd_t                 cmd,
	output dfs_pkg::dfs_stat_t                stat,
	input  logic                              cfg_valid,
	input  logic [dfs_pkg::CIDX_W-1:0]        cfg_index,
	input  logic [31:0]                       cfg_data,
	input  logic                              mode,
	input  logic signed [dfs_pkg::MAG_W-1:0]  mag_x,
	input  logic signed [dfs_pkg::MAG_W-1:0]  mag_y,
	input  logic signed [dfs_pkg::MAG_W-1:0]  mag_z,
	output logic signed [dfs_pkg::FIELD_W-1:0] field_x,
	output logic signed [dfs_pkg::FIELD_W-1:0] field_y,
	output logic signed [dfs_pkg::FIELD_W-1:0] field_z,
	output logic                              last_cell
);
	import dfs_pkg::*;

	localparam int XW    = $clog2(MAX_X + 1);
	localparam int YW    = $clog2(MAX_Y + 1);
	localparam int ZW    = $clog2(MAX_Z + 1);
	localparam int XYW   = XW + YW;
	localparam int PW    = XYW + ZW + 1;
	localparam int DEPTH = 2 * MAX_X * MAX_Y + MAX_X + 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int WW    = 3 * MAG_W;

	// configuration registers
	logic [6:0]                size_x_q, size_y_q;
	logic [4:0]                size_z_q;
	logic signed [MAG_W-1:0]   axis_q [3];
	logic signed [SCALE_W-1:0] scale_q;

	logic [XW-1:0] x_cl;
	logic [YW-1:0] y_cl;
	logic [ZW-1:0] z_cl;
	logic [XYW-1:0] xy_q;
	logic [PW-1:0] n_q, lag_q, nlag_q;

	logic [PW-1:0] k_q;
	logic [AW-1:0] wp_q, rp_q;
	logic [XW-1:0] ox_q;
	logic [YW-1:0] oy_q;
	logic [ZW-1:0] oz_q;
	logic          last_q;

	logic [WW-1:0] mem [DEPTH];

	logic item_ok, produce, is_last, size_wr;

	always_comb begin
		if (size_x_q == 7'd0) begin
			x_cl = XW'(1);
		end else if (int'(size_x_q) > MAX_X) begin
			x_cl = XW'(MAX_X);
		end else begin
			x_cl = XW'(size_x_q);
		end
		if (size_y_q == 7'd0) begin
			y_cl = YW'(1);
		end else if (int'(size_y_q) > MAX_Y) begin
			y_cl = YW'(MAX_Y);
		end else begin
			y_cl = YW'(size_y_q);
		end
		if (size_z_q == 5'd0) begin
			z_cl = ZW'(1);
		end else if (int'(size_z_q) > MAX_Z) begin
			z_cl = ZW'(MAX_Z);
		end else begin
			z_cl = ZW'(size_z_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q  <= 7'd64;
			size_y_q  <= 7'd64;
			size_z_q  <= 5'd16;
			axis_q[0] <= '0;
			axis_q[1] <= '0;
			axis_q[2] <= 16'sd16384;
			scale_q   <= 32'sd65536;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SIZE_X: size_x_q  <= cfg_data[6:0];
				CFG_SIZE_Y: size_y_q  <= cfg_data[6:0];
				CFG_SIZE_Z: size_z_q  <= cfg_data[4:0];
				CFG_AXIS_X: axis_q[0] <= $signed(cfg_data[15:0]);
				CFG_AXIS_Y: axis_q[1] <= $signed(cfg_data[15:0]);
				CFG_AXIS_Z: axis_q[2] <= $signed(cfg_data[15:0]);
				CFG_SCALE:  scale_q   <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	assign size_wr = cfg_valid && (cfg_index == CFG_SIZE_X || cfg_index == CFG_SIZE_Y ||
		cfg_index == CFG_SIZE_Z);

	// grid geometry, settles after a size write through xy_q, n_q and lag_q, then nlag_q
	always_ff @(posedge clk) begin
		xy_q   <= XYW'(x_cl) * XYW'(y_cl);
		n_q    <= PW'(xy_q) * PW'(z_cl);
		lag_q  <= PW'(xy_q) + PW'(x_cl) + PW'(1);
		nlag_q <= n_q + lag_q;
	end

	assign item_ok = mode ? (k_q >= n_q && k_q < nlag_q) : (k_q < n_q);
	assign produce = item_ok && k_q >= lag_q;
	assign is_last = produce && (k_q + PW'(1) == nlag_q);
	assign stat.produce = produce;
	assign stat.size_wr = size_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			wp_q   <= '0;
			rp_q   <= '0;
			ox_q   <= '0;
			oy_q   <= '0;
			oz_q   <= '0;
			last_q <= 1'b0;
		end else if (size_wr) begin
			k_q  <= '0;
			wp_q <= '0;
			rp_q <= '0;
			ox_q <= '0;
			oy_q <= '0;
			oz_q <= '0;
		end else begin
			if (cmd.accept && item_ok) begin
				last_q <= is_last;
				if (is_last) begin
					k_q  <= '0;
					wp_q <= '0;
				end else begin
					k_q  <= k_q + PW'(1);
					wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
				end
			end
			if (cmd.load_out) begin
				if (last_q) begin
					rp_q <= '0;
					ox_q <= '0;
					oy_q <= '0;
					oz_q <= '0;
				end else begin
					rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
					if (ox_q == XW'(x_cl - XW'(1))) begin
						ox_q <= '0;
						if (oy_q == YW'(y_cl - YW'(1))) begin
							oy_q <= '0;
							oz_q <= oz_q + ZW'(1);
						end else begin
							oy_q <= oy_q + YW'(1);
						end
					end else begin
						ox_q <= ox_q + XW'(1);
					end
				end
			end
		end
	end

	// window store
	always_ff @(posedge clk) begin
		if (cmd.accept && item_ok && !mode) begin
			mem[wp_q] <= {mag_x, mag_y, mag_z};
		end
	end

	// neighbour address: +-1, +-X, +-XY around the center, wrapped in the ring
	logic [AW:0] off, up, dn, rp_ext;
	logic [AW-1:0] rd_addr;
	logic          nb_in;

	always_comb begin
		rp_ext = {1'b0, rp_q};
		case (cmd.rd_idx[2:1])
			2'd0:    off = (AW + 1)'(1);
			2'd1:    off = (AW + 1)'(x_cl);
			default: off = (AW + 1)'(xy_q);
		endcase
		up = rp_ext + off;
		if (up >= (AW + 1)'(DEPTH)) begin
			up = up - (AW + 1)'(DEPTH);
		end
		if (rp_ext >= off) begin
			dn = rp_ext - off;
		end else begin
			dn = rp_ext + (AW + 1)'(DEPTH) - off;
		end
		rd_addr = cmd.rd_idx[0] ? dn[AW-1:0] : up[AW-1:0];
		case (cmd.rd_idx)
			3'd0:    nb_in = ox_q != XW'(x_cl - XW'(1));
			3'd1:    nb_in = ox_q != '0;
			3'd2:    nb_in = oy_q != YW'(y_cl - YW'(1));
			3'd3:    nb_in = oy_q != '0;
			3'd4:    nb_in = oz_q != ZW'(z_cl - ZW'(1));
			3'd5:    nb_in = oz_q != '0;
			default: nb_in = 1'b0;
		endcase
	end

	logic [WW-1:0] rdata_s1;
	logic          rv_s1, rin_s1;
	logic [2:0]    ri_s1;

	always_ff @(posedge clk) begin
		rdata_s1 <= mem[rd_addr];
		ri_s1    <= cmd.rd_idx;
		rin_s1   <= nb_in;
	end

	logic signed [MAG_W-1:0]  m_s1 [3];
	logic signed [MAG_W-1:0]  m_s2 [3];
	logic signed [PROD_W-1:0] p_s2 [3];
	logic                     rv_s2;
	logic [2:0]               ri_s2;

	assign m_s1[0] = rin_s1 ? $signed(rdata_s1[WW-1:2*MAG_W]) : '0;
	assign m_s1[1] = rin_s1 ? $signed(rdata_s1[2*MAG_W-1:MAG_W]) : '0;
	assign m_s1[2] = rin_s1 ? $signed(rdata_s1[MAG_W-1:0]) : '0;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			m_s2[c] <= m_s1[c];
			p_s2[c] <= axis_q[c] * m_s1[c];
		end
		ri_s2 <= ri_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
			rv_s2 <= 1'b0;
		end else begin
			rv_s1 <= cmd.rd_en;
			rv_s2 <= rv_s1;
		end
	end

	// divergence and gradient accumulation
	logic signed [DOT_W-1:0]  dot;
	logic signed [MAG_W-1:0]  m_sel;
	logic signed [DIV_W-1:0]  div_q;
	logic signed [GRAD_W-1:0] grad_q [3];

	always_comb begin
		dot = DOT_W'(p_s2[0]) + DOT_W'(p_s2[1]) + DOT_W'(p_s2[2]);
		case (ri_s2[2:1])
			2'd0:    m_sel = m_s2[0];
			2'd1:    m_sel = m_s2[1];
			default: m_sel = m_s2[2];
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			div_q <= '0;
			for (int c = 0; c < 3; c++) begin
				grad_q[c] <= '0;
			end
		end else if (rv_s2) begin
			if (ri_s2[0]) begin
				div_q <= div_q - DIV_W'(m_sel);
			end else begin
				div_q <= div_q + DIV_W'(m_sel);
			end
			for (int c = 0; c < 3; c++) begin
				if (ri_s2[2:1] == 2'(c)) begin
					if (ri_s2[0]) begin
						grad_q[c] <= grad_q[c] - GRAD_W'(dot);
					end else begin
						grad_q[c] <= grad_q[c] + GRAD_W'(dot);
					end
				end
			end
		end
	end

	logic signed [T_W-1:0] t_q [3];

	always_ff @(posedge clk) begin
		if (cmd.term_en) begin
			for (int c = 0; c < 3; c++) begin
				t_q[c] <= T_W'(axis_q[c]) * T_W'(div_q) - T_W'(grad_q[c]);
			end
		end
	end

	// scaling: t split at the binary point so each product stays narrow
	logic signed [T_W-1:0]  t_sel;
	logic signed [LO_W-1:0] lo_s1;
	logic signed [HI_W-1:0] hi_s1;
	logic                   sv_s1;
	logic [1:0]             sc_s1;

	always_comb begin
		case (cmd.sc_comp)
			2'd0:    t_sel = t_q[0];
			2'd1:    t_sel = t_q[1];
			default: t_sel = t_q[2];
		endcase
	end

	always_ff @(posedge clk) begin
		lo_s1 <= $signed({1'b0, t_sel[FRAC_W-1:0]}) * scale_q;
		hi_s1 <= $signed(t_sel[T_W-1:FRAC_W]) * scale_q;
		sc_s1 <= cmd.sc_comp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_s1 <= 1'b0;
		end else begin
			sv_s1 <= cmd.sc_en;
		end
	end

	logic signed [LO_W:0]    lo_rnd;
	logic signed [R_W-1:0]   r_sum;
	logic signed [FIELD_W-1:0] r_sat;
	logic signed [FIELD_W-1:0] res_q [3];

	always_comb begin
		lo_rnd = (LO_W + 1)'(lo_s1) + (LO_W + 1)'(64'sd1 <<< (FRAC_W - 1));
		r_sum  = R_W'(hi_s1) + R_W'(lo_rnd >>> FRAC_W);
		if (!r_sum[R_W-1] && (|r_sum[R_W-2:FIELD_W-1])) begin
			r_sat = {1'b0, {(FIELD_W - 1){1'b1}}};
		end else if (r_sum[R_W-1] && !(&r_sum[R_W-2:FIELD_W-1])) begin
			r_sat = {1'b1, {(FIELD_W - 1){1'b0}}};
		end else begin
			r_sat = r_sum[FIELD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (sv_s1) begin
			case (sc_s1)
				2'd0:    res_q[0] <= r_sat;
				2'd1:    res_q[1] <= r_sat;
				default: res_q[2] <= r_sat;
			endcase
		end
		if (cmd.load_out) begin
			field_x   <= res_q[0];
			field_y   <= res_q[1];
			field_z   <= res_q[2];
			last_cell <= last_q;
		end
	end

endmodule

@@ sv/dmi_field_stencil_3d_top.sv @@
// dmi effective field over a 3d grid, seven-point stencil on a raster stream.
// input channel: in_valid/in_stall with mode, mag_x, mag_y, mag_z. cells come
// in raster order, x fastest; after the last cell, size_x*size_y+size_x+1
// drain items (mode 1) flush the remaining fields.
// output channel: out_valid/out_stall with field_x/y/z and last_cell, one
// field per cell in raster order; last_cell marks the final cell of a grid.
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; the user
// writes it only while the block is idle (the block does not enforce this);
// a size write restarts the grid. an item that yields no field is taken in
// idle and leaves the block ready for the next item. an item that yields a
// field passes six neighbour reads on the single read port of the window
// store, the term, and three components on the shared scaling multiplier.
// the output register lets the next item in while a field waits; when the
// receiver stalls and a new field is ready, the block holds off input.
// after reset and after a size write the block settles the grid geometry
// before taking items; config writes are always taken.
module dmi_field_stencil_3d_top #(
	parameter int MAX_X = 64,
	parameter int MAX_Y = 64,
	parameter int MAX_Z = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode,
	input  logic signed [dfs_pkg::MAG_W-1:0]    mag_x,
	input  logic signed [dfs_pkg::MAG_W-1:0]    mag_y,
	input  logic signed [dfs_pkg::MAG_W-1:0]    mag_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [dfs_pkg::FIELD_W-1:0]  field_x,
	output logic signed [dfs_pkg::FIELD_W-1:0]  field_y,
	output logic signed [dfs_pkg::FIELD_W-1:0]  field_z,
	output logic                                last_cell,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dfs_pkg::CIDX_W-1:0]          cfg_index,
	input  logic [31:0]                         cfg_data
);
	import dfs_pkg::*;

	dfs_cmd_t  cmd;
	dfs_stat_t stat;

	assign cfg_ready = 1'b1;

	dfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	dfs_datapath #(
		.MAX_X (MAX_X),
		.MAX_Y (MAX_Y),
		.MAX_Z (MAX_Z)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mode      (mode),
		.mag_x     (mag_x),
		.mag_y     (mag_y),
		.mag_z     (mag_z),
		.field_x   (field_x),
		.field_y   (field_y),
		.field_z   (field_z),
		.last_cell (last_cell)
	);

endmodule

@@ tb/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dfs_pkg::*;

	localparam int GX = 64;
	localparam int GY = 64;
	localparam int GZ = 16;

	typedef struct {
		logic signed [FIELD_W-1:0] fx;
		logic signed [FIELD_W-1:0] fy;
		logic signed [FIELD_W-1:0] fz;
		logic                      last;
	} field_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic                       mode;
	logic signed [MAG_W-1:0]    mag_x;
	logic signed [MAG_W-1:0]    mag_y;
	logic signed [MAG_W-1:0]    mag_z;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [FIELD_W-1:0]  field_x;
	logic signed [FIELD_W-1:0]  field_y;
	logic signed [FIELD_W-1:0]  field_z;
	logic                       last_cell;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CIDX_W-1:0]          cfg_index;
	logic [31:0]                cfg_data;

	dmi_field_stencil_3d_top #(
		.MAX_X(GX),
		.MAX_Y(GY),
		.MAX_Z(GZ)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.mag_x(mag_x),
		.mag_y(mag_y),
		.mag_z(mag_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.field_x(field_x),
		.field_y(field_y),
		.field_z(field_z),
		.last_cell(last_cell),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// grid model: cells kept by raster position
	logic signed [MAG_W-1:0] cell_mag [0:GX*GY*GZ-1][0:2];
	int unsigned   in_pos;
	int unsigned   raw_x, raw_y, raw_z;
	longint        axis_n [0:2];
	longint        k_scale;
	field_t        pending_fields [$];

	int            snd_idle;
	int            rcv_stall;
	bit            rcv_hold;
	int            errors;
	int            useful_items;
	int            fields_seen;
	int            grids_done;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("timeout at %0t", $time);
		$display("simulation failed");
		$finish;
	end

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic longint mag_at(longint x, longint y, longint z, int c);
		longint nx, ny, nz;
		nx = clamp_dim(raw_x, GX);
		ny = clamp_dim(raw_y, GY);
		nz = clamp_dim(raw_z, GZ);
		if (x < 0 || y < 0 || z < 0 || x >= nx || y >= ny || z >= nz)
			return 0;
		return longint'(cell_mag[x + nx * (y + ny * z)][c]);
	endfunction

	function automatic longint dot_at(longint x, longint y, longint z);
		return axis_n[0] * mag_at(x, y, z, 0) + axis_n[1] * mag_at(x, y, z, 1) +
			axis_n[2] * mag_at(x, y, z, 2);
	endfunction

	// round to nearest, ties up, then saturate
	function automatic logic signed [FIELD_W-1:0] scale_field(longint t);
		logic signed [127:0] p;
		logic signed [127:0] tt;
		logic signed [127:0] ss;
		tt = t;
		ss = k_scale;
		p = (tt * ss + (128'sd1 <<< 27)) >>> FRAC_W;
		if (p > 128'sd2147483647) return 32'sh7fffffff;
		if (p < -128'sd2147483648) return 32'sh80000000;
		return p[FIELD_W-1:0];
	endfunction

	// returns 1 when the item is taken into the grid
	function automatic bit predict_field(bit md, logic signed [15:0] a,
			logic signed [15:0] b, logic signed [15:0] c);
		int unsigned nx, ny, nz, n, lag, k, q;
		longint x, y, z, dv;
		longint gr [0:2];
		field_t f;
		nx = clamp_dim(raw_x, GX);
		ny = clamp_dim(raw_y, GY);
		nz = clamp_dim(raw_z, GZ);
		n = nx * ny * nz;
		lag = nx * ny + nx + 1;
		k = in_pos;
		if (!md && k >= n) return 0;
		if (md && (k < n || k >= n + lag)) return 0;
		if (!md) begin
			cell_mag[k][0] = a;
			cell_mag[k][1] = b;
			cell_mag[k][2] = c;
		end
		in_pos = k + 1;
		if (k < lag) return 1;
		q = k - lag;
		x = q % nx;
		y = (q / nx) % ny;
		z = q / (nx * ny);
		dv = (mag_at(x + 1, y, z, 0) - mag_at(x - 1, y, z, 0)) +
			(mag_at(x, y + 1, z, 1) - mag_at(x, y - 1, z, 1)) +
			(mag_at(x, y, z + 1, 2) - mag_at(x, y, z - 1, 2));
		gr[0] = dot_at(x + 1, y, z) - dot_at(x - 1, y, z);
		gr[1] = dot_at(x, y + 1, z) - dot_at(x, y - 1, z);
		gr[2] = dot_at(x, y, z + 1) - dot_at(x, y, z - 1);
		f.fx = scale_field(axis_n[0] * dv - gr[0]);
		f.fy = scale_field(axis_n[1] * dv - gr[1]);
		f.fz = scale_field(axis_n[2] * dv - gr[2]);
		f.last = (q == n - 1);
		if (f.last) begin
			in_pos = 0;
			grids_done++;
		end
		pending_fields.push_back(f);
		return 1;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_item(bit md, logic signed [15:0] a, logic signed [15:0] b,
			logic signed [15:0] c);
		while ($urandom_range(99) < snd_idle)
			@(negedge clk);
		in_valid = 1'b1;
		mode = md;
		mag_x = a;
		mag_y = b;
		mag_z = c;
		do @(posedge clk); while (in_stall);
		if (predict_field(md, a, b, c))
			useful_items++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_fields.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [31:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SIZE_X: raw_x = val[6:0];
			CFG_SIZE_Y: raw_y = val[6:0];
			CFG_SIZE_Z: raw_z = val[4:0];
			CFG_AXIS_X: axis_n[0] = longint'($signed(val[15:0]));
			CFG_AXIS_Y: axis_n[1] = longint'($signed(val[15:0]));
			CFG_AXIS_Z: axis_n[2] = longint'($signed(val[15:0]));
			CFG_SCALE:  k_scale = longint'($signed(val));
			default: ;
		endcase
		if (idx == CFG_SIZE_X || idx == CFG_SIZE_Y || idx == CFG_SIZE_Z)
			in_pos = 0;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_grid(int sx, int sy, int sz);
		cfg_write(CFG_SIZE_X, 32'(sx));
		cfg_write(CFG_SIZE_Y, 32'(sy));
		cfg_write(CFG_SIZE_Z, 32'(sz));
	endtask

	function automatic logic signed [15:0] rnd_mag();
		if ($urandom_range(15) == 0) return 16'($urandom);
		return 16'($signed($urandom_range(32768)) - 16384);
	endfunction

	// whole grid of random cells then its drains; noise adds ignored items
	task automatic run_grid(bit noisy);
		int unsigned n, lag;
		n = clamp_dim(raw_x, GX) * clamp_dim(raw_y, GY) * clamp_dim(raw_z, GZ);
		lag = clamp_dim(raw_x, GX) * clamp_dim(raw_y, GY) + clamp_dim(raw_x, GX) + 1;
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(7) == 0)
				send_item(1'b1, rnd_mag(), rnd_mag(), rnd_mag());
			send_item(1'b0, rnd_mag(), rnd_mag(), rnd_mag());
		end
		for (int i = 0; i < lag; i++) begin
			if (noisy && $urandom_range(7) == 0)
				send_item(1'b0, rnd_mag(), rnd_mag(), rnd_mag());
			send_item(1'b1, rnd_mag(), rnd_mag(), rnd_mag());
		end
	endtask

	task automatic test_directed_extremes();
		logic signed [15:0] ext [0:3];
		ext[0] = 16'sd16384;
		ext[1] = -16'sd16384;
		ext[2] = 16'sh7fff;
		ext[3] = 16'sh8000;
		snd_idle = 0;
		rcv_stall = 0;
		set_grid(2, 2, 2);
		cfg_write(CFG_AXIS_X, 32'hffffc000);
		cfg_write(CFG_AXIS_Y, 32'h00004000);
		cfg_write(CFG_AXIS_Z, 32'h00004000);
		cfg_write(CFG_SCALE, 32'h7fffffff);
		// drain before the grid is complete is ignored
		send_item(1'b1, 16'sd0, 16'sd0, 16'sd0);
		for (int i = 0; i < 8; i++)
			send_item(1'b0, ext[i % 4], ext[(i + 1) % 4], ext[(i + 3) % 4]);
		// cell after the grid is complete is ignored
		send_item(1'b0, ext[0], ext[1], ext[2]);
		for (int i = 0; i < 7; i++)
			send_item(1'b1, 16'sd0, 16'sd0, 16'sd0);
		wait_idle();
		// zero sizes clamp to one
		set_grid(0, 0, 0);
		cfg_write(CFG_SCALE, 32'h80000000);
		send_item(1'b0, ext[3], ext[2], ext[1]);
		for (int i = 0; i < 3; i++)
			send_item(1'b1, 16'sd0, 16'sd0, 16'sd0);
		wait_idle();
	endtask

	task automatic test_clamped_sizes();
		snd_idle = 10;
		rcv_stall = 10;
		cfg_write(CFG_SCALE, 32'h00010000);
		set_grid(127, 1, 1);
		run_grid(1'b0);
		wait_idle();
		set_grid(1, 127, 1);
		run_grid(1'b0);
		wait_idle();
		set_grid(1, 1, 31);
		run_grid(1'b0);
		wait_idle();
	endtask

	task automatic test_dropped_grid();
		set_grid(3, 3, 2);
		for (int i = 0; i < 16; i++)
			send_item(1'b0, rnd_mag(), rnd_mag(), rnd_mag());
		wait_idle();
		// scale change mid-grid applies to the next field
		cfg_write(CFG_SCALE, 32'hfffe8000);
		for (int i = 0; i < 2; i++)
			send_item(1'b0, rnd_mag(), rnd_mag(), rnd_mag());
		wait_idle();
		// size write abandons the grid in progress
		set_grid(3, 2, 2);
		run_grid(1'b0);
		wait_idle();
	endtask

	task automatic test_backpressure();
		snd_idle = 0;
		rcv_stall = 0;
		set_grid(3, 3, 3);
		fork
			begin
				rcv_hold = 1'b1;
				repeat (400) @(posedge clk);
				rcv_hold = 1'b0;
			end
			begin
				for (int i = 0; i < 30; i++)
					send_item(1'b0, rnd_mag(), rnd_mag(), rnd_mag());
			end
		join
		// sender waits for every pending field before going on
		while (pending_fields.size() != 0)
			@(negedge clk);
		for (int i = 30; i < 30 + 13; i++)
			send_item(i < 27 ? 1'b0 : 1'b1, rnd_mag(), rnd_mag(), rnd_mag());
		wait_idle();
	endtask

	task automatic test_random_grids();
		int start;
		int done_cnt;
		start = useful_items;
		while (useful_items - start < 90) begin
			done_cnt = useful_items - start;
			if (done_cnt < 30) begin
				snd_idle = 13;
				rcv_stall = 62;
			end else if (done_cnt < 60) begin
				snd_idle = 62;
				rcv_stall = 13;
			end else begin
				snd_idle = 0;
				rcv_stall = 0;
			end
			set_grid($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 2));
			cfg_write(CFG_AXIS_X, 32'($signed($urandom_range(32768)) - 16384));
			cfg_write(CFG_AXIS_Y, 32'($signed($urandom_range(32768)) - 16384));
			cfg_write(CFG_AXIS_Z, 32'($signed($urandom_range(32768)) - 16384));
			if ($urandom_range(3) == 0)
				cfg_write(CFG_SCALE, $urandom);
			else
				cfg_write(CFG_SCALE, 32'($signed($urandom_range(32'h80000)) - 32'sh40000));
			run_grid($urandom_range(4) == 0);
			wait_idle();
		end
	endtask

	always @(negedge clk) begin
		out_stall <= rcv_hold || ($urandom_range(99) < rcv_stall);
	end

	always @(posedge clk) begin
		field_t e;
		if (arst_n && out_valid && !out_stall) begin
			fields_seen++;
			if (pending_fields.size() == 0) begin
				errors++;
				$display("%0t: unexpected field x=%0d y=%0d z=%0d last=%0b", $time,
					field_x, field_y, field_z, last_cell);
			end else begin
				e = pending_fields.pop_front();
				if (field_x !== e.fx) begin
					errors++;
					$display("%0t: field_x exp %0d got %0d", $time, e.fx, field_x);
				end
				if (field_y !== e.fy) begin
					errors++;
					$display("%0t: field_y exp %0d got %0d", $time, e.fy, field_y);
				end
				if (field_z !== e.fz) begin
					errors++;
					$display("%0t: field_z exp %0d got %0d", $time, e.fz, field_z);
				end
				if (last_cell !== e.last) begin
					errors++;
					$display("%0t: last_cell exp %0b got %0b", $time, e.last, last_cell);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = 1'b0;
		mag_x = '0;
		mag_y = '0;
		mag_z = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		rcv_hold = 1'b0;
		snd_idle = 0;
		rcv_stall = 0;
		errors = 0;
		useful_items = 0;
		fields_seen = 0;
		grids_done = 0;
		in_pos = 0;
		raw_x = 64;
		raw_y = 64;
		raw_z = 16;
		axis_n[0] = 0;
		axis_n[1] = 0;
		axis_n[2] = 16384;
		k_scale = 65536;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_extremes();
		test_clamped_sizes();
		test_dropped_grid();
		test_backpressure();
		test_random_grids();

		snd_idle = 0;
		rcv_stall = 0;
		for (int i = 0; i < 20000 && pending_fields.size() != 0; i++)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (pending_fields.size() != 0) begin
			errors++;
			$display("%0t: %0d fields never arrived", $time, pending_fields.size());
		end
		$display("covered %0d grid items, %0d fields checked, %0d grids finished",
			useful_items, fields_seen, grids_done);
		$display("grid sizes clamped and dropped, saturating scales, long output hold-off");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
